/* sv/rpc_pkg.sv */
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants for the radial probe clearance block
// Action and status codes, probe ring/direction tables, sequencer state and
// the request/response structs between the sequencer and the probe unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  localparam int DEF_MAX_BOXES  = 64;
  localparam int DEF_COORD_BITS = 24;

  localparam int RADIUS_W    = 12;
  localparam int R2_W        = 2 * RADIUS_W;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int CLR_W       = 10;
  localparam int BOX_COUNT_W = 7;

  localparam int RING_COUNT = 4;
  localparam int RING_W     = 2;
  localparam int DIR_W      = 3;
  localparam int PROBE_W    = RING_W + DIR_W;
  localparam int OFF_W      = 14;
  localparam int PROBE_LAT  = 4;
  localparam int DRAIN_W    = 2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd80;
  localparam logic [CLR_W-1:0]    CLEAR_METRES = 10'd800;

  localparam logic [ACTION_W-1:0] ACT_CLEAR     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD       = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_QUERY_ALT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STORED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ANSWER  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [PROBE_W-1:0] probe;
  } probe_req_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [RING_W-1:0] ring;
  } probe_res_t;

  // ring radius in eighths of a metre, axis or diagonal component
  function automatic logic signed [OFF_W-1:0] ring_offset(input logic [RING_W-1:0] ring,
                                                          input logic diag);
    logic signed [OFF_W-1:0] off;
    unique case (ring)
      2'd0: off = diag ? 14'sd566  : 14'sd800;
      2'd1: off = diag ? 14'sd1131 : 14'sd1600;
      2'd2: off = diag ? 14'sd2263 : 14'sd3200;
      2'd3: off = diag ? 14'sd3394 : 14'sd4800;
    endcase
    return off;
  endfunction

  // sign of cos for direction k*45 deg: +1, 0, -1
  function automatic logic signed [1:0] dir_cos(input logic [DIR_W-1:0] dir);
    logic signed [1:0] s;
    unique case (dir)
      3'd0, 3'd1, 3'd7: s = 2'sd1;
      3'd2, 3'd6:       s = 2'sd0;
      default:          s = -2'sd1;
    endcase
    return s;
  endfunction

  function automatic logic signed [1:0] dir_sin(input logic [DIR_W-1:0] dir);
    logic signed [1:0] s;
    unique case (dir)
      3'd1, 3'd2, 3'd3: s = 2'sd1;
      3'd0, 3'd4:       s = 2'sd0;
      default:          s = -2'sd1;
    endcase
    return s;
  endfunction

  function automatic logic [CLR_W-1:0] first_ring_metres(input logic [RING_COUNT-1:0] hits);
    logic [CLR_W-1:0] m;
    if (hits[0]) begin
      m = 10'd100;
    end else if (hits[1]) begin
      m = 10'd200;
    end else if (hits[2]) begin
      m = 10'd400;
    end else if (hits[3]) begin
      m = 10'd600;
    end else begin
      m = CLEAR_METRES;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* sv/rpc_box_mem.sv */
// ----------------------------------------------------------------------------
// rpc_box_mem: obstacle box storage
// One write port, one registered read port. Contents undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_box_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 144
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/rpc_probe_unit.sv */
// ----------------------------------------------------------------------------
// rpc_probe_unit: shared probe-versus-box contact test
// Four stages: probe point, per-axis clamp gap, squares, sum and radius compare.
// One probe/box pair enters per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_probe_unit
  import rpc_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire probe_req_t                   req,
  input  wire logic signed [COORD_BITS-1:0] qx,
  input  wire logic signed [COORD_BITS-1:0] qy,
  input  wire logic signed [COORD_BITS-1:0] qz,
  input  wire logic        [R2_W-1:0]       r2,
  input  wire logic        [6*COORD_BITS-1:0] box,
  output probe_res_t                        res
);

  localparam int CW   = COORD_BITS + 2;
  localparam int GW   = CW - 1;
  localparam int SQW  = 2 * GW;
  localparam int SUMW = SQW + 2;
  localparam int CB   = COORD_BITS;

  function automatic logic signed [CW-1:0] sext(input logic signed [CB-1:0] v);
    return {{2{v[CB-1]}}, v};
  endfunction

  function automatic logic [GW-1:0] gap(input logic signed [CW-1:0] p,
                                        input logic signed [CW-1:0] lo,
                                        input logic signed [CW-1:0] hi);
    logic signed [CW-1:0] dlo;
    logic signed [CW-1:0] dhi;
    logic        [GW-1:0] g;
    dlo = lo - p;
    dhi = p - hi;
    if (!dlo[CW-1] && dlo != '0) begin
      g = dlo[GW-1:0];
    end else if (!dhi[CW-1] && dhi != '0) begin
      g = dhi[GW-1:0];
    end else begin
      g = '0;
    end
    return g;
  endfunction

  logic                    s0_valid, s1_valid, s2_valid;
  logic [RING_W-1:0]       s0_ring, s1_ring, s2_ring;
  logic signed [CW-1:0]    s0_px, s0_py;
  logic [GW-1:0]           gx, gy, gz;
  logic [SQW-1:0]          sqx, sqy, sqz;

  logic [RING_W-1:0]       req_ring;
  logic [DIR_W-1:0]        req_dir;
  logic signed [OFF_W-1:0] off;
  logic signed [CW-1:0]    off_e;
  logic signed [CW-1:0]    dx, dy;
  logic [SUMW-1:0]         sum;

  assign req_ring = req.probe[PROBE_W-1 -: RING_W];
  assign req_dir  = req.probe[DIR_W-1:0];
  assign off      = ring_offset(req_ring, req_dir[0]);
  assign off_e    = {{(CW-OFF_W){off[OFF_W-1]}}, off};

  always_comb begin
    unique case (dir_cos(req_dir))
      2'sd1:   dx = off_e;
      -2'sd1:  dx = -off_e;
      default: dx = '0;
    endcase
    unique case (dir_sin(req_dir))
      2'sd1:   dy = off_e;
      -2'sd1:  dy = -off_e;
      default: dy = '0;
    endcase
  end

  assign sum = SUMW'(sqx) + SUMW'(sqy) + SUMW'(sqz);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      s0_valid  <= req.valid;
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      res.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s0_ring  <= req_ring;
    s0_px    <= sext(qx) + dx;
    s0_py    <= sext(qy) + dy;

    s1_ring  <= s0_ring;
    gx       <= gap(s0_px,    sext(box[6*CB-1 -: CB]), sext(box[3*CB-1 -: CB]));
    gy       <= gap(s0_py,    sext(box[5*CB-1 -: CB]), sext(box[2*CB-1 -: CB]));
    gz       <= gap(sext(qz), sext(box[4*CB-1 -: CB]), sext(box[CB-1 -: CB]));

    s2_ring  <= s1_ring;
    sqx      <= gx * gx;
    sqy      <= gy * gy;
    sqz      <= gz * gz;

    res.ring <= s2_ring;
    res.hit  <= (sum <= SUMW'(r2));
  end

endmodule

`default_nettype wire

/* sv/rpc_ctrl.sv */
// ----------------------------------------------------------------------------
// rpc_ctrl: command sequencer
// Decodes clear/add/query, keeps the box count and radius register, walks
// every stored box against all 32 probes and folds the ring hits.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_ctrl
  import rpc_pkg::*;
#(
  parameter int MAX_BOXES  = DEF_MAX_BOXES,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int AW         = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
  parameter int CNTW       = $clog2(MAX_BOXES + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ACTION_W-1:0]          action,
  input  wire logic signed [COORD_BITS-1:0] query_x,
  input  wire logic signed [COORD_BITS-1:0] query_y,
  input  wire logic signed [COORD_BITS-1:0] query_z,
  input  wire logic                         cfg_we,
  input  wire logic [RADIUS_W-1:0]          cfg_data,
  input  wire probe_res_t                   res,
  output logic                              busy,
  output logic                              mem_we,
  output logic [AW-1:0]                     waddr,
  output logic [AW-1:0]                     raddr,
  output probe_req_t                        req,
  output logic signed [COORD_BITS-1:0]      qx,
  output logic signed [COORD_BITS-1:0]      qy,
  output logic signed [COORD_BITS-1:0]      qz,
  output logic [R2_W-1:0]                   r2,
  output logic                              done,
  output logic [STATUS_W-1:0]               status,
  output logic [CLR_W-1:0]                  clearance_m,
  output logic [BOX_COUNT_W-1:0]            box_count
);

  state_t                state, state_next;
  logic [CNTW-1:0]       count, count_next;
  logic [AW-1:0]         box_idx, box_idx_next;
  logic [PROBE_W-1:0]    probe, probe_next;
  logic [RING_COUNT-1:0] hits, hits_next, res_hits;
  logic [DRAIN_W-1:0]    drain, drain_next;
  logic                  done_next;
  logic [STATUS_W-1:0]   status_next;
  logic [CLR_W-1:0]      clr_next;
  logic [RADIUS_W-1:0]   body_radius;
  logic                  query_load;

  assign busy      = (state != S_IDLE);
  assign waddr     = count[AW-1:0];
  assign raddr     = box_idx;
  assign box_count = BOX_COUNT_W'(count);
  assign res_hits  = (res.valid && res.hit) ? (RING_COUNT'(1) << res.ring) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      box_idx     <= '0;
      probe       <= '0;
      hits        <= '0;
      drain       <= '0;
      done        <= 1'b0;
      status      <= ST_CLEARED;
      clearance_m <= '0;
      body_radius <= RADIUS_RESET;
    end else begin
      state       <= state_next;
      count       <= count_next;
      box_idx     <= box_idx_next;
      probe       <= probe_next;
      hits        <= hits_next;
      drain       <= drain_next;
      done        <= done_next;
      status      <= status_next;
      clearance_m <= clr_next;
      if (cfg_we) begin
        body_radius <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_load) begin
      qx <= query_x;
      qy <= query_y;
      qz <= query_z;
      r2 <= R2_W'(body_radius) * R2_W'(body_radius);
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    box_idx_next = box_idx;
    probe_next   = probe;
    hits_next    = hits | res_hits;
    drain_next   = drain;
    done_next    = 1'b0;
    status_next  = status;
    clr_next     = clearance_m;
    mem_we       = 1'b0;
    query_load   = 1'b0;
    req.valid    = 1'b0;
    req.probe    = probe;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (action) inside
            ACT_CLEAR: begin
              count_next  = '0;
              done_next   = 1'b1;
              status_next = ST_CLEARED;
              clr_next    = '0;
            end
            ACT_ADD: begin
              done_next = 1'b1;
              clr_next  = '0;
              if (count < CNTW'(MAX_BOXES)) begin
                mem_we      = 1'b1;
                count_next  = count + CNTW'(1);
                status_next = ST_STORED;
              end else begin
                status_next = ST_FULL;
              end
            end
            ACT_QUERY, ACT_QUERY_ALT: begin
              query_load = 1'b1;
              if (count == '0) begin
                done_next   = 1'b1;
                status_next = ST_ANSWER;
                clr_next    = CLEAR_METRES;
              end else begin
                state_next   = S_SCAN;
                box_idx_next = '0;
                probe_next   = '0;
                hits_next    = '0;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        req.valid  = 1'b1;
        probe_next = probe + PROBE_W'(1);
        if (probe == '1) begin
          box_idx_next = box_idx + AW'(1);
          if (CNTW'(box_idx) == count - CNTW'(1)) begin
            state_next = S_DRAIN;
            drain_next = DRAIN_W'(PROBE_LAT - 1);
          end
        end
      end
      S_DRAIN: begin
        drain_next = drain - DRAIN_W'(1);
        if (drain == '0) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          status_next = ST_ANSWER;
          clr_next    = first_ring_metres(hits | res_hits);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_BOXES))
    else $error("box count above table size");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CNTW'(box_idx) < count))
    else $error("scan reads past stored boxes");

  a_res_in_query: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == S_SCAN || state == S_DRAIN))
    else $error("probe result outside a query");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_CLEAR) |=>
      (done && status == ST_CLEARED && count == '0))
    else $error("clear did not answer next cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while sequencer active");
`endif

endmodule

`default_nettype wire

/* sv/radial_probe_clearance_top.sv */
// ----------------------------------------------------------------------------
// radial_probe_clearance_top: obstacle clearance estimator
// Box table with add/clear, and radial probe query over 4 rings x 8 headings.
//
//   channel   ports                                          transfer when
//   command   start, busy, action, box_min_*, box_max_*,     start && !busy
//             query_x/y/z
//   result    done, status, clearance_m, box_count           done (one cycle)
//   config    cfg_we, cfg_data (body_radius)                 cfg_we
//
// Clear and add: result in the cycle after the command transfer.
// Query: result after a scan of all N boxes held (next cycle if N = 0);
// the probe unit tests one probe point against one stored box per cycle.
// busy is high from the query transfer until the result cycle.
// Synchronous reset empties the table and sets body_radius to 80.
// Results cannot be stalled; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_probe_clearance_top
  import rpc_pkg::*;
#(
  parameter int MAX_BOXES  = DEF_MAX_BOXES,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ACTION_W-1:0]          action,
  input  wire logic signed [COORD_BITS-1:0] box_min_x,
  input  wire logic signed [COORD_BITS-1:0] box_min_y,
  input  wire logic signed [COORD_BITS-1:0] box_min_z,
  input  wire logic signed [COORD_BITS-1:0] box_max_x,
  input  wire logic signed [COORD_BITS-1:0] box_max_y,
  input  wire logic signed [COORD_BITS-1:0] box_max_z,
  input  wire logic signed [COORD_BITS-1:0] query_x,
  input  wire logic signed [COORD_BITS-1:0] query_y,
  input  wire logic signed [COORD_BITS-1:0] query_z,
  input  wire logic                         cfg_we,
  input  wire logic [RADIUS_W-1:0]          cfg_data,
  output logic                              done,
  output logic [STATUS_W-1:0]               status,
  output logic [CLR_W-1:0]                  clearance_m,
  output logic [BOX_COUNT_W-1:0]            box_count
);

  localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNTW = $clog2(MAX_BOXES + 1);
  localparam int DW   = 6 * COORD_BITS;

  logic                         mem_we;
  logic [AW-1:0]                waddr, raddr;
  logic [DW-1:0]                wdata, rdata;
  probe_req_t                   req;
  probe_res_t                   res;
  logic signed [COORD_BITS-1:0] qx, qy, qz;
  logic [R2_W-1:0]              r2;

  assign wdata = {box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z};

  rpc_ctrl #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS),
    .AW         (AW),
    .CNTW       (CNTW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .query_x     (query_x),
    .query_y     (query_y),
    .query_z     (query_z),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .res         (res),
    .busy        (busy),
    .mem_we      (mem_we),
    .waddr       (waddr),
    .raddr       (raddr),
    .req         (req),
    .qx          (qx),
    .qy          (qy),
    .qz          (qz),
    .r2          (r2),
    .done        (done),
    .status      (status),
    .clearance_m (clearance_m),
    .box_count   (box_count)
  );

  rpc_box_mem #(
    .DEPTH (MAX_BOXES),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rpc_probe_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_probe (
    .clk (clk),
    .rst (rst),
    .req (req),
    .qx  (qx),
    .qy  (qy),
    .qz  (qz),
    .r2  (r2),
    .box (rdata),
    .res (res)
  );

endmodule

`default_nettype wire

/* tb/sv/radial_probe_clearance_top_test.sv */
// ----------------------------------------------------------------------------
// radial_probe_clearance_top_test: self-checking bench for the clearance block
// Drives clear/add/query commands from a pending queue with random idle gaps,
// predicts each response with a local box table and radial probe search, and
// compares every done strobe field by field. body_radius is rewritten between
// phases (0, 4095 and others); random scenarios cluster boxes and queries
// around a center so that every ring, touch and miss case is reached.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_probe_clearance_top_test
  import rpc_pkg::*;
();

  localparam int CW          = DEF_COORD_BITS;
  localparam int TABLE_DEPTH = DEF_MAX_BOXES;
  localparam int STALL_LIMIT = 10000;
  localparam int SETTLE      = 8;

  localparam logic [55:0] AXIS_OFF = {14'd4800, 14'd3200, 14'd1600, 14'd800};
  localparam logic [55:0] DIAG_OFF = {14'd3394, 14'd2263, 14'd1131, 14'd566};
  localparam logic [39:0] RING_M   = {10'd600, 10'd400, 10'd200, 10'd100};

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic signed [CW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, q_x, q_y, q_z;
  } command_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [CLR_W-1:0]       clearance;
    logic [BOX_COUNT_W-1:0] count;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [ACTION_W-1:0] action = ACT_CLEAR;
  logic signed [CW-1:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
  logic signed [CW-1:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
  logic signed [CW-1:0] query_x = '0, query_y = '0, query_z = '0;
  logic cfg_we = 1'b0;
  logic [RADIUS_W-1:0] cfg_data = '0;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [CLR_W-1:0] clearance_m;
  logic [BOX_COUNT_W-1:0] box_count;

  radial_probe_clearance_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
    .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
    .query_x(query_x), .query_y(query_y), .query_z(query_z),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .status(status), .clearance_m(clearance_m), .box_count(box_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  command_t pending [$];
  reply_t   owed_replies [$];
  command_t on_bus;
  reply_t   oldest;

  longint box_lo [TABLE_DEPTH][3];
  longint box_hi [TABLE_DEPTH][3];
  int held_boxes = 0;
  logic [RADIUS_W-1:0] radius_now = RADIUS_RESET;

  int queued = 0, accepted = 0, errors = 0, quiet = 0, idle_pct = 37;
  int n_clears = 0, n_adds = 0, n_drops = 0, n_queries = 0, n_blocked = 0;
  int radius_writes = 0;
  bit draining = 1'b0;
  bit send;

  function automatic bit probe_blocked(longint px, longint py, longint pz);
    longint pt [3];
    longint lim, gap_sq, c, d;
    int i, a;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    lim = longint'(radius_now) * longint'(radius_now);
    for (i = 0; i < held_boxes; i++) begin
      gap_sq = 0;
      for (a = 0; a < 3; a++) begin
        c = pt[a];
        if (c < box_lo[i][a]) c = box_lo[i][a];
        else if (c > box_hi[i][a]) c = box_hi[i][a];
        d = pt[a] - c;
        gap_sq += d * d;
      end
      if (gap_sq <= lim) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [CLR_W-1:0] nearest_blocked_ring(longint qx, longint qy, longint qz);
    longint dx, dy, off;
    int r, k;
    for (r = 0; r < RING_COUNT; r++) begin
      for (k = 0; k < 8; k++) begin
        dx = (k == 0 || k == 1 || k == 7) ? 1 : (k == 2 || k == 6) ? 0 : -1;
        dy = (k >= 1 && k <= 3) ? 1 : (k == 0 || k == 4) ? 0 : -1;
        off = (dx != 0 && dy != 0) ? longint'(DIAG_OFF[r*14 +: 14])
                                   : longint'(AXIS_OFF[r*14 +: 14]);
        if (probe_blocked(qx + dx * off, qy + dy * off, qz)) return RING_M[r*10 +: 10];
      end
    end
    return CLEAR_METRES;
  endfunction

  function automatic reply_t predict_reply(command_t c);
    reply_t r;
    r.clearance = '0;
    case (c.act)
      ACT_CLEAR: begin
        held_boxes = 0;
        r.status = ST_CLEARED;
        n_clears++;
      end
      ACT_ADD: begin
        n_adds++;
        if (held_boxes < TABLE_DEPTH) begin
          box_lo[held_boxes][0] = longint'($signed(c.lo_x));
          box_lo[held_boxes][1] = longint'($signed(c.lo_y));
          box_lo[held_boxes][2] = longint'($signed(c.lo_z));
          box_hi[held_boxes][0] = longint'($signed(c.hi_x));
          box_hi[held_boxes][1] = longint'($signed(c.hi_y));
          box_hi[held_boxes][2] = longint'($signed(c.hi_z));
          held_boxes++;
          r.status = ST_STORED;
        end else begin
          r.status = ST_FULL;
          n_drops++;
        end
      end
      default: begin
        r.clearance = nearest_blocked_ring(longint'($signed(c.q_x)),
                                           longint'($signed(c.q_y)),
                                           longint'($signed(c.q_z)));
        r.status = ST_ANSWER;
        n_queries++;
        if (r.clearance != CLEAR_METRES) n_blocked++;
      end
    endcase
    r.count = BOX_COUNT_W'(held_boxes);
    return r;
  endfunction

  // driver: one item on the command port, held until transfer
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        owed_replies.insert(owed_replies.size(), predict_reply(on_bus));
        accepted++;
      end
      if (draining && owed_replies.size() == 0) draining = 1'b0;
      if (!start || !busy) begin
        if (!draining && idle_pct != 0 && pending.size() != 0 && $urandom_range(99) < 3)
          draining = 1'b1;
        send = !draining && pending.size() != 0 && $urandom_range(99) >= idle_pct;
        if (send) begin
          on_bus = pending.pop_front();
          action    <= on_bus.act;
          box_min_x <= on_bus.lo_x;
          box_min_y <= on_bus.lo_y;
          box_min_z <= on_bus.lo_z;
          box_max_x <= on_bus.hi_x;
          box_max_y <= on_bus.hi_y;
          box_max_z <= on_bus.hi_z;
          query_x   <= on_bus.q_x;
          query_y   <= on_bus.q_y;
          query_z   <= on_bus.q_z;
        end
        start <= send;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (owed_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d clearance=%0d count=%0d",
                 $time, status, clearance_m, box_count);
      end else begin
        oldest = owed_replies.pop_front();
        if (status !== oldest.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, oldest.status, status);
        end
        if (clearance_m !== oldest.clearance) begin
          errors++;
          $display("%0t: clearance_m mismatch: expected %0d, got %0d",
                   $time, oldest.clearance, clearance_m);
        end
        if (box_count !== oldest.count) begin
          errors++;
          $display("%0t: box_count mismatch: expected %0d, got %0d",
                   $time, oldest.count, box_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results owed",
               $time, quiet, owed_replies.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic command_t junk_cmd();
    command_t c;
    c.act  = ACTION_W'($urandom_range(3));
    c.lo_x = CW'($urandom);
    c.lo_y = CW'($urandom);
    c.lo_z = CW'($urandom);
    c.hi_x = CW'($urandom);
    c.hi_y = CW'($urandom);
    c.hi_z = CW'($urandom);
    c.q_x  = CW'($urandom);
    c.q_y  = CW'($urandom);
    c.q_z  = CW'($urandom);
    return c;
  endfunction

  function automatic void wipe();
    command_t c;
    c = junk_cmd();
    c.act = ACT_CLEAR;
    pending.insert(pending.size(), c);
    queued++;
  endfunction

  function automatic void add_box(int lx, int ly, int lz, int hx, int hy, int hz);
    command_t c;
    c = junk_cmd();
    c.act  = ACT_ADD;
    c.lo_x = CW'(lx);
    c.lo_y = CW'(ly);
    c.lo_z = CW'(lz);
    c.hi_x = CW'(hx);
    c.hi_y = CW'(hy);
    c.hi_z = CW'(hz);
    pending.insert(pending.size(), c);
    queued++;
  endfunction

  function automatic void ask(int qx, int qy, int qz, logic [ACTION_W-1:0] op);
    command_t c;
    c = junk_cmd();
    c.act = op;
    c.q_x = CW'(qx);
    c.q_y = CW'(qy);
    c.q_z = CW'(qz);
    pending.insert(pending.size(), c);
    queued++;
  endfunction

  function automatic int near(int base, int span);
    return base + int'($urandom_range(2 * span)) - span;
  endfunction

  // boxes scattered around one center, then queries near it
  task automatic queue_scenario(int adds, int asks, bit keep_table);
    int cx, cy, cz, lx, ly, lz, hx, hy, hz, t, i, sw;
    if ($urandom_range(9) < 3) begin
      cx = int'($urandom_range(16760000)) - 8380000;
      cy = int'($urandom_range(16760000)) - 8380000;
      cz = int'($urandom_range(16760000)) - 8380000;
    end else begin
      cx = int'($urandom_range(200000)) - 100000;
      cy = int'($urandom_range(200000)) - 100000;
      cz = int'($urandom_range(20000)) - 10000;
    end
    if (!keep_table) wipe();
    for (i = 0; i < adds; i++) begin
      lx = near(cx, 5200);
      ly = near(cy, 5200);
      lz = near(cz, 200);
      hx = lx + int'($urandom_range(500));
      hy = ly + int'($urandom_range(500));
      hz = lz + int'($urandom_range(300));
      sw = int'($urandom_range(9));
      if (sw == 0) begin
        t = lx; lx = hx; hx = t;
      end else if (sw == 1) begin
        t = ly; ly = hy; hy = t;
      end else if (sw == 2) begin
        t = lz; lz = hz; hz = t;
      end
      add_box(lx, ly, lz, hx, hy, hz);
    end
    for (i = 0; i < asks; i++) begin
      ask(near(cx, 3000), near(cy, 3000), near(cz, 250),
          ($urandom_range(7) == 0) ? ACT_QUERY_ALT : ACT_QUERY);
    end
  endtask

  task automatic wait_quiet();
    while (accepted != queued || owed_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] r);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_now = r;
    radius_writes++;
  endtask

  initial begin
    int p, mark, sel;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset radius of 80
    ask(0, 0, 0, ACT_QUERY);
    ask(8388607, 8388607, 8388607, ACT_QUERY);
    add_box(790, -10, -10, 810, 10, 10);
    ask(0, 0, 0, ACT_QUERY);
    ask(0, 0, 0, ACT_QUERY_ALT);
    wipe();
    add_box(1211, 1121, -10, 1300, 1140, 10);
    ask(0, 0, 0, ACT_QUERY);
    ask(-1, 0, 0, ACT_QUERY);
    add_box(5000, -5, -5, 4000, 5, 5);
    ask(200, 0, 0, ACT_QUERY);
    ask(-4000, 0, 80, ACT_QUERY_ALT);
    add_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
    ask(-8388608, -8388608, -8388608, ACT_QUERY);
    ask(8388607, 0, -8388608, ACT_QUERY);
    wipe();
    add_box(8388607, 8388607, 8388607, -8388608, -8388608, -8388608);
    ask(8388607, 8388607, 8388607, ACT_QUERY);
    ask(8383000, 8388607, 8388607, ACT_QUERY);
    wipe();
    add_box(-3400, -3400, -3, -3390, -3390, 3);
    ask(0, 0, 0, ACT_QUERY);
    ask(0, 0, 84, ACT_QUERY);

    for (p = 0; p < 6; p++) begin
      wait_quiet();
      case (p)
        0: write_radius(12'd0);
        1: write_radius(12'd4095);
        2: write_radius(12'd1);
        3: write_radius(RADIUS_W'($urandom_range(4095)));
        4: write_radius(12'd200);
        default: write_radius(RADIUS_W'($urandom_range(300)));
      endcase
      idle_pct = (p == 2) ? 0 : 37;
      mark = queued;
      if (p == 1 || p == 4) queue_scenario(70, 3, 1'b0);
      while (queued - mark < 65) begin
        sel = int'($urandom_range(99));
        if (sel < 12) begin
          pending.insert(pending.size(), junk_cmd());
          queued++;
        end else begin
          queue_scenario(int'($urandom_range(6)), 1 + int'($urandom_range(5)), sel < 30);
        end
      end
    end
    wait_quiet();

    $display("run covered %0d commands: %0d clears, %0d adds (%0d dropped on full table),",
             accepted, n_clears, n_adds, n_drops);
    $display("%0d queries (%0d blocked) over %0d body radius settings",
             n_queries, n_blocked, radius_writes + 1);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
